// File: src/aes128_variant_block_cipher_unit_macros.svh
// Assertion macros for the cipher unit.
`ifndef AES128_VARIANT_BLOCK_CIPHER_UNIT_MACROS_SVH
`define AES128_VARIANT_BLOCK_CIPHER_UNIT_MACROS_SVH
`ifndef SYNTH
`define AES_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("assertion failed");
`define AES_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AES_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define AES_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/aesv_pkg.sv
// Types, tables and round functions for the modified AES-128 cipher unit.
package aesv_pkg;

  localparam int unsigned NR = 10;
  localparam logic [7:0] FIELD_LOW = 8'h4D;
  localparam logic [7:0] AFFINE_CONST = 8'h15;

  typedef logic [7:0] byte_t;
  typedef logic [0:15][7:0] state_t;
  typedef byte_t sbox_arr_t [256];
  typedef byte_t rcon_arr_t [NR];

  typedef enum logic {
    REQ_ENCRYPT = 1'b0,
    REQ_DECRYPT = 1'b1
  } req_kind_t;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic        req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } req_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } result_t;

  function automatic byte_t gf_dbl(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? FIELD_LOW : 8'h00);
  endfunction

  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t acc;
    byte_t p;
    acc = '0;
    p = b;
    for (int i = 0; i < 8; i++) begin
      if (a[i]) acc = acc ^ p;
      p = gf_dbl(p);
    end
    return acc;
  endfunction

  function automatic byte_t gf_inv(byte_t a);
    byte_t r;
    byte_t p;
    r = 8'h01;
    p = a;
    for (int e = 0; e < 8; e++) begin
      if (e != 0) r = gf_mul(r, p);
      p = gf_mul(p, p);
    end
    return r;
  endfunction

  function automatic byte_t rotl(byte_t x, int unsigned n);
    return byte_t'((x << n) | (x >> (8 - n)));
  endfunction

  function automatic sbox_arr_t gen_sbox();
    sbox_arr_t t;
    byte_t b;
    for (int i = 0; i < 256; i++) begin
      b = gf_inv(byte_t'(i));
      t[i] = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ AFFINE_CONST;
    end
    return t;
  endfunction

  function automatic sbox_arr_t gen_inv_sbox();
    sbox_arr_t f;
    sbox_arr_t t;
    f = gen_sbox();
    for (int i = 0; i < 256; i++) t[f[i]] = byte_t'(i);
    return t;
  endfunction

  function automatic rcon_arr_t gen_rcon();
    rcon_arr_t t;
    byte_t rc;
    rc = 8'h01;
    for (int i = 0; i < NR; i++) begin
      t[i] = rc;
      rc = gf_dbl(rc);
    end
    return t;
  endfunction

  localparam sbox_arr_t SBOX = gen_sbox();
  localparam sbox_arr_t INV_SBOX = gen_inv_sbox();
  localparam rcon_arr_t RCON = gen_rcon();

  function automatic state_t sub_bytes(state_t s);
    state_t t;
    for (int i = 0; i < 16; i++) t[i] = SBOX[s[i]];
    return t;
  endfunction

  function automatic state_t inv_sub_bytes(state_t s);
    state_t t;
    for (int i = 0; i < 16; i++) t[i] = INV_SBOX[s[i]];
    return t;
  endfunction

  function automatic state_t shift_rows(state_t s);
    state_t t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[r + 4 * c] = s[r + 4 * ((c + r) % 4)];
    return t;
  endfunction

  function automatic state_t inv_shift_rows(state_t s);
    state_t t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[r + 4 * ((c + r) % 4)] = s[r + 4 * c];
    return t;
  endfunction

  function automatic state_t mix_cols(state_t s, byte_t c0, byte_t c1, byte_t c2, byte_t c3);
    state_t t;
    byte_t coef [4];
    coef[0] = c0; coef[1] = c1; coef[2] = c2; coef[3] = c3;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        t[4 * c + r] = '0;
        for (int n = 0; n < 4; n++)
          t[4 * c + r] = t[4 * c + r] ^ gf_mul(coef[(n - r + 4) % 4], s[4 * c + n]);
      end
    return t;
  endfunction

  // Next round key from the previous one.
  function automatic state_t key_fwd(state_t p, byte_t rc);
    state_t q;
    q[0] = p[0] ^ SBOX[p[13]] ^ rc;
    q[1] = p[1] ^ SBOX[p[14]];
    q[2] = p[2] ^ SBOX[p[15]];
    q[3] = p[3] ^ SBOX[p[12]];
    for (int i = 4; i < 16; i++) q[i] = p[i] ^ q[i - 4];
    return q;
  endfunction

  // Previous round key from the next one; rc is the constant that made q.
  function automatic state_t key_bwd(state_t q, byte_t rc);
    state_t p;
    for (int i = 4; i < 16; i++) p[i] = q[i] ^ q[i - 4];
    p[0] = q[0] ^ SBOX[p[13]] ^ rc;
    p[1] = q[1] ^ SBOX[p[14]];
    p[2] = q[2] ^ SBOX[p[15]];
    p[3] = q[3] ^ SBOX[p[12]];
    return p;
  endfunction

endpackage

// File: src/aes128_variant_block_cipher_unit.sv
// Pipelined modified AES-128 encrypt/decrypt unit, one block per cycle.
// A block is taken on every cycle that start is high (busy stays low) and its result
// appears on result, from the last pipeline stage register, with done high for one cycle.
// The 21-stage pipeline has an input stage adding the first round key for encrypt,
// ten stages that expand the key forward (and run the encrypt rounds), and ten
// stages that walk the key schedule backward for the decrypt rounds. The key
// registers are read at entry; a new key applies to transactions started after it.
`include "aes128_variant_block_cipher_unit_macros.svh"
module aes128_variant_block_cipher_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  aesv_pkg::req_t   req,
  output logic             done,
  output aesv_pkg::result_t result,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [63:0]      cfg_data
);
  import aesv_pkg::*;

  localparam int unsigned LAST = 2 * NR;

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        vld  [LAST + 1];
  logic        mode [LAST + 1];
  state_t      data [LAST + 1];
  state_t      rkey [LAST + 1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage: encrypt adds round key 0 here.
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= start;
    mode[0] <= req.req_type;
    rkey[0] <= {key_high, key_low};
    data[0] <= (req.req_type == REQ_ENCRYPT)
               ? ({req.block_high, req.block_low} ^ {key_high, key_low})
               : {req.block_high, req.block_low};
  end

  // Forward stages: round key k, encrypt round k, decrypt takes the last key.
  for (genvar k = 1; k <= NR; k++) begin : g_fwd
    state_t k_next;
    state_t e_next;
    assign k_next = key_fwd(rkey[k - 1], RCON[k - 1]);
    always_comb begin
      e_next = shift_rows(sub_bytes(data[k - 1]));
      if (k != NR) e_next = mix_cols(e_next, 8'h02, 8'h03, 8'h01, 8'h01);
      e_next = e_next ^ k_next;
    end
    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else     vld[k] <= vld[k - 1];
      mode[k] <= mode[k - 1];
      rkey[k] <= k_next;
      if (mode[k - 1] == REQ_ENCRYPT) data[k] <= e_next;
      else if (k == NR)              data[k] <= data[k - 1] ^ k_next;
      else                           data[k] <= data[k - 1];
    end
  end

  // Backward stages: decrypt round r with round key r, derived from key r+1.
  for (genvar m = 1; m <= NR; m++) begin : g_bwd
    localparam int unsigned R = NR - m;
    state_t k_prev;
    state_t d_next;
    assign k_prev = key_bwd(rkey[NR + m - 1], RCON[R]);
    always_comb begin
      d_next = inv_sub_bytes(inv_shift_rows(data[NR + m - 1])) ^ k_prev;
      if (R != 0) d_next = mix_cols(d_next, 8'h0E, 8'h0B, 8'h0D, 8'h09);
    end
    always_ff @(posedge clk) begin
      if (rst) vld[NR + m] <= 1'b0;
      else     vld[NR + m] <= vld[NR + m - 1];
      mode[NR + m] <= mode[NR + m - 1];
      rkey[NR + m] <= k_prev;
      data[NR + m] <= (mode[NR + m - 1] == REQ_DECRYPT) ? d_next : data[NR + m - 1];
    end
  end

  assign done = vld[LAST];
  assign result = result_t'(data[LAST]);

  `AES_ASSERT_IMP(a_latency, clk, rst, start && !busy, ##21 done)
  `AES_ASSERT_IMP(a_no_phantom, clk, rst, done, $past(start, 21))
  `AES_ASSERT_IMP(a_key_walk, clk, rst, vld[LAST] && mode[LAST] == REQ_DECRYPT, rkey[LAST] == $past(rkey[0], 20))

endmodule
